// ===== src/cms_pkg.sv =====
// Package: types, constants and hash constants for the count-min sketch.
`timescale 1ns / 1ps
package cms_pkg;
   localparam int ROWS      = 4;
   localparam int MAX_WIDTH = 1024;
   localparam int STORE     = ROWS * MAX_WIDTH;
   localparam int ADDR_W    = $clog2(STORE);
   localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int LANE_W    = $clog2(MAX_WIDTH + 1);

   localparam logic [63:0] MIX1  = 64'hff51afd7ed558ccd;
   localparam logic [63:0] MIX2  = 64'hc4ceb9fe1a85ec53;
   localparam logic [63:0] GOLD  = 64'h9E3779B97F4A7C15;
   localparam logic [63:0] ROWK  = 64'hBF58476D1CE4E5B9;

   typedef enum logic [1:0] {
      ACT_RECORD  = 2'd0,
      ACT_ESTIMATE = 2'd1,
      ACT_COMPARE = 2'd2,
      ACT_NONE    = 2'd3
   } action_type;

   localparam logic [1:0] REG_ENABLE = 2'd0;
   localparam logic [1:0] REG_WIDTH  = 2'd1;
   localparam logic [1:0] REG_AGING  = 2'd2;

   typedef struct packed {
      logic [1:0]  action;
      logic [31:0] page;
      logic [31:0] victim_page;
      logic        has_victim;
   } req_type;

   typedef struct packed {
      logic [7:0] estimate;
      logic [7:0] victim_estimate;
      logic       loses;
   } rsp_type;

   // hash unit handshake
   typedef struct packed {
      logic        start;
      logic [31:0] page;
      logic [ROW_W-1:0] row;
   } hreq_type;

   typedef struct packed {
      logic              done;
      logic [ADDR_W-1:0] addr;
   } hrsp_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_CLEAR, ST_AGE_MOD, ST_AGE_RD, ST_AGE_WR, ST_HASH, ST_HWAIT,
      ST_RD, ST_RDWAIT, ST_UPD, ST_NEXT, ST_DONE
   } state_type;

   typedef enum logic [3:0] {
      HS_IDLE, HS_M0, HS_M1, HS_M2, HS_M3, HS_SUM, HS_X1, HS_MUL1, HS_X2,
      HS_MUL2, HS_X3, HS_MOD, HS_OUT
   } hstate_type;
endpackage

// ===== src/cms_ram.sv =====
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module cms_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (we) mem[addr] <= wdata;
      rdata <= mem[addr];
   end
endmodule

// ===== src/cms_hash.sv =====
// Multi-cycle hash unit: splitmix finalizer and modulo reduction per row.
`timescale 1ns / 1ps
module cms_hash import cms_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  hreq_type          hreq,
   input  logic [LANE_W-1:0] width,
   output hrsp_type          hrsp
);
   hstate_type state_ff, state_in;
   logic [63:0] x_ff, x_in;
   logic [63:0] acc_ff, acc_in;
   logic [63:0] opa_ff, opa_in;
   logic [63:0] opb_ff, opb_in;
   logic [1:0]  pp_ff, pp_in;
   logic [6:0]  bit_ff, bit_in;
   logic [LANE_W-1:0] rem_ff, rem_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [31:0] prod;
   logic [63:0] pp_sh;
   logic [LANE_W:0] rsh;

   // 32x32 partial products, three per 64x64 low product
   always_comb begin
      case (pp_ff)
         2'd0: prod = opa_ff[31:0] * opb_ff[31:0];
         2'd1: prod = opa_ff[31:0] * opb_ff[63:32];
         2'd2: prod = opa_ff[63:32] * opb_ff[31:0];
         default: prod = '0;
      endcase
   end

   // full 64-bit low product needs the low x low partial at full width
   logic [63:0] lowprod;
   assign lowprod = 64'(opa_ff[31:0]) * 64'(opb_ff[31:0]);

   always_comb begin
      case (pp_ff)
         2'd0: pp_sh = lowprod;
         default: pp_sh = {prod, 32'd0};
      endcase
   end

   assign rsh = {rem_ff, x_ff[bit_ff[5:0]]};

   always_comb begin
      state_in = state_ff;
      x_in = x_ff; acc_in = acc_ff; opa_in = opa_ff; opb_in = opb_ff;
      pp_in = pp_ff; bit_in = bit_ff; rem_in = rem_ff; row_in = row_ff;
      case (state_ff)
         HS_IDLE: if (hreq.start) begin
            row_in = hreq.row;
            opa_in = {32'd0, hreq.page};
            opb_in = GOLD;
            acc_in = '0; pp_in = '0;
            state_in = HS_M0;
         end
         HS_M0, HS_MUL1, HS_MUL2: begin
            acc_in = acc_ff + pp_sh;
            if (pp_ff == 2'd2) begin
               pp_in = '0;
               case (state_ff)
                  HS_M0:   state_in = HS_SUM;
                  HS_MUL1: state_in = HS_X2;
                  default: state_in = HS_X3;
               endcase
            end else pp_in = pp_ff + 2'd1;
         end
         HS_SUM: begin
            x_in = acc_ff + 64'(row_ff) * ROWK;
            state_in = HS_X1;
         end
         HS_X1: begin
            opa_in = x_ff ^ (x_ff >> 33); opb_in = MIX1;
            acc_in = '0; pp_in = '0; state_in = HS_MUL1;
         end
         HS_X2: begin
            opa_in = acc_ff ^ (acc_ff >> 33); opb_in = MIX2;
            acc_in = '0; pp_in = '0; state_in = HS_MUL2;
         end
         HS_X3: begin
            x_in = acc_ff ^ (acc_ff >> 33);
            rem_in = '0; bit_in = 7'd63; state_in = HS_MOD;
         end
         HS_MOD: begin
            // restoring division, one bit per cycle
            if (rsh >= (LANE_W+1)'(width)) rem_in = LANE_W'(rsh - (LANE_W+1)'(width));
            else rem_in = LANE_W'(rsh);
            if (bit_ff == 7'd0) state_in = HS_OUT;
            else bit_in = bit_ff - 7'd1;
         end
         HS_OUT: state_in = HS_IDLE;
         default: state_in = HS_IDLE;
      endcase
   end

   logic [ADDR_W+LANE_W-1:0] lane;
   assign lane = (ADDR_W+LANE_W)'(row_ff) * (ADDR_W+LANE_W)'(width)
               + (ADDR_W+LANE_W)'(rem_ff);

   always_comb begin
      hrsp.done = (state_ff == HS_OUT);
      hrsp.addr = (lane < (ADDR_W+LANE_W)'(STORE)) ? ADDR_W'(lane) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= HS_IDLE;
      else state_ff <= state_in;
      x_ff <= x_in; acc_ff <= acc_in; opa_ff <= opa_in; opb_ff <= opb_in;
      pp_ff <= pp_in; bit_ff <= bit_in; rem_ff <= rem_in; row_ff <= row_in;
   end
endmodule

// ===== src/count_min_frequency_sketch.sv =====
// Top level: count-min frequency sketch sequencer, counter store and registers.
`timescale 1ns / 1ps
// Count-min sketch with aging for cache admission. Pulse start with a request
// while busy is low; estimate and compare results appear for one cycle on
// rsp_valid, in the same cycle that the block drops busy, and cannot be stalled.
// After reset the block clears the counter store (busy high). Each row runs
// through the shared hash unit (64-bit products as three 32x32 partials each,
// then a bit-serial 64-step modulo) plus issue, read, update and advance. An
// estimate runs the four rows once and a compare with a victim once per page;
// a record first takes a 32-step remainder of the record count by the aging
// period, then the four rows, with the remainder skipped when aging is off.
// A record that triggers aging adds a read-halve-write sweep over the store.
// When disabled, estimates and compares go straight to the response and
// records are dropped at once.
module count_min_frequency_sketch import cms_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_data,
   output logic        rsp_valid,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   state_type state_ff, state_in;
   logic        enable_ff;
   logic [10:0] width_ff;
   logic [31:0] period_ff;
   logic [31:0] count_ff, count_in;
   logic [31:0] arem_ff, arem_in;
   logic [4:0]  abit_ff, abit_in;
   req_type     req_ff, req_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic        second_ff, second_in;
   logic [7:0]  min_ff, min_in;
   logic [7:0]  cest_ff, cest_in;
   logic [ADDR_W:0] sweep_ff, sweep_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   rsp_type     rsp_ff, rsp_in;
   logic        rspv_ff, rspv_in;

   logic              we;
   logic [ADDR_W-1:0] ram_addr;
   logic [7:0]        wdata, rdata;
   hreq_type          hreq;
   hrsp_type          hrsp;
   logic [LANE_W-1:0] eff_w;
   logic [32:0]       arsh;
   logic [31:0]       arem_nx;

   assign eff_w = (width_ff == 11'd0) ? LANE_W'(1) :
                  (32'(width_ff) > 32'(MAX_WIDTH)) ? LANE_W'(MAX_WIDTH) :
                  LANE_W'(width_ff);

   cms_hash u_hash (.clock(clock), .reset(reset), .hreq(hreq), .width(eff_w), .hrsp(hrsp));

   cms_ram #(.WIDTH(8), .DEPTH(STORE)) u_ram (
      .clock(clock), .we(we), .addr(ram_addr), .wdata(wdata), .rdata(rdata));

   assign csr_ready = 1'b1;
   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rspv_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0; width_ff <= 11'd1024; period_ff <= 32'd4096;
      end else if (csr_valid) begin
         case (csr_index)
            REG_ENABLE: enable_ff <= csr_wdata[0];
            REG_WIDTH:  width_ff  <= csr_wdata[10:0];
            REG_AGING:  period_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // restoring remainder of the record count by the aging period, MSB first
   assign arsh    = {arem_ff, count_ff[abit_ff]};
   assign arem_nx = (arsh >= {1'b0, period_ff}) ? 32'(arsh - {1'b0, period_ff}) : arsh[31:0];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: if (sweep_ff == (ADDR_W+1)'(STORE - 1)) state_in = ST_IDLE;
         ST_IDLE: if (start) begin
            case (req_data.action)
               ACT_RECORD:  state_in = !enable_ff ? ST_IDLE :
                                       (period_ff != 32'd0) ? ST_AGE_MOD : ST_HASH;
               ACT_ESTIMATE, ACT_COMPARE: state_in = enable_ff ? ST_HASH : ST_DONE;
               default: state_in = ST_IDLE;
            endcase
         end
         ST_AGE_MOD: if (abit_ff == 5'd0) state_in = (arem_nx == 32'd0) ? ST_AGE_RD : ST_HASH;
         ST_AGE_RD: state_in = ST_AGE_WR;
         ST_AGE_WR: state_in = (sweep_ff == (ADDR_W+1)'(STORE - 1)) ? ST_HASH : ST_AGE_RD;
         ST_HASH:   state_in = ST_HWAIT;
         ST_HWAIT:  if (hrsp.done) state_in = ST_RD;
         ST_RD:     state_in = ST_RDWAIT;
         ST_RDWAIT: state_in = ST_UPD;
         ST_UPD:    state_in = ST_NEXT;
         ST_NEXT: begin
            if (32'(row_ff) == 32'(ROWS - 1)) begin
               if (req_ff.action == ACT_RECORD) state_in = ST_IDLE;
               else if (req_ff.action == ACT_COMPARE && req_ff.has_victim && !second_ff)
                  state_in = ST_HASH;
               else state_in = ST_DONE;
            end else state_in = ST_HASH;
         end
         ST_DONE:   state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      count_in = count_ff; arem_in = arem_ff; abit_in = abit_ff; req_in = req_ff;
      row_in = row_ff;
      second_in = second_ff; min_in = min_ff; cest_in = cest_ff; sweep_in = sweep_ff;
      addr_in = addr_ff; rsp_in = rsp_ff; rspv_in = 1'b0;
      we = 1'b0; ram_addr = addr_ff; wdata = '0;
      hreq.start = 1'b0;
      hreq.page = second_ff ? req_ff.victim_page : req_ff.page;
      hreq.row = row_ff;
      case (state_ff)
         ST_CLEAR: begin
            we = 1'b1; ram_addr = ADDR_W'(sweep_ff); sweep_in = sweep_ff + (ADDR_W+1)'(1);
         end
         ST_IDLE: begin
            sweep_in = '0;
            if (start) begin
               req_in = req_data; row_in = '0; second_in = 1'b0; min_in = 8'd255;
               cest_in = '0; arem_in = '0; abit_in = 5'd31;
               if (req_data.action == ACT_RECORD && enable_ff) count_in = count_ff + 32'd1;
            end
         end
         ST_AGE_MOD: begin
            arem_in = arem_nx;
            if (abit_ff != 5'd0) abit_in = abit_ff - 5'd1;
         end
         ST_AGE_RD: ram_addr = ADDR_W'(sweep_ff);
         ST_AGE_WR: begin
            we = 1'b1; ram_addr = ADDR_W'(sweep_ff); wdata = {1'b0, rdata[7:1]};
            sweep_in = sweep_ff + (ADDR_W+1)'(1);
         end
         ST_HASH: hreq.start = 1'b1;
         ST_HWAIT: if (hrsp.done) addr_in = hrsp.addr;
         ST_RD, ST_RDWAIT: ;
         ST_UPD: begin
            if (req_ff.action == ACT_RECORD) begin
               we = 1'b1; wdata = (rdata == 8'd255) ? rdata : rdata + 8'd1;
            end else if (rdata < min_ff) min_in = rdata;
         end
         ST_NEXT: begin
            if (32'(row_ff) == 32'(ROWS - 1)) begin
               row_in = '0;
               if (!second_ff) begin
                  cest_in = min_ff; second_in = 1'b1; min_in = 8'd255;
               end
            end else row_in = row_ff + ROW_W'(1);
         end
         ST_DONE: begin
            rspv_in = 1'b1;
            if (!enable_ff) begin
               rsp_in.estimate = '0; rsp_in.victim_estimate = '0;
               rsp_in.loses = (req_ff.action == ACT_COMPARE) && req_ff.has_victim;
            end else if (req_ff.action == ACT_COMPARE && req_ff.has_victim) begin
               rsp_in.estimate = cest_ff; rsp_in.victim_estimate = min_ff;
               rsp_in.loses = (cest_ff <= min_ff);
            end else begin
               rsp_in.estimate = cest_ff; rsp_in.victim_estimate = '0;
               rsp_in.loses = 1'b0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR; count_ff <= '0; sweep_ff <= '0;
         rspv_ff <= 1'b0;
      end else begin
         state_ff <= state_in; count_ff <= count_in;
         sweep_ff <= sweep_in; rspv_ff <= rspv_in;
      end
      req_ff <= req_in; row_ff <= row_in; second_ff <= second_in; min_ff <= min_in;
      cest_ff <= cest_in; addr_ff <= addr_in; rsp_ff <= rsp_in;
      arem_ff <= arem_in; abit_ff <= abit_in;
   end
endmodule

// ===== tb/count_min_frequency_sketch_tb.sv =====
// Testbench for the count-min frequency sketch: directed table, then random traffic.
`timescale 1ns / 1ps
module count_min_frequency_sketch_tb;
   import cms_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   req_type     req_data = '0;
   logic        rsp_valid;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;

   count_min_frequency_sketch i_dut (.*);

   always #6 clock = ~clock;

   // shadow of the sketch
   logic [7:0]  shadow_cnt [STORE];
   logic [31:0] shadow_records;
   logic        cfg_enable;
   logic [10:0] cfg_width;
   logic [31:0] cfg_aging;

   rsp_type pending_rsp [$];
   int      error_count = 0;
   int      idle_pct = 22;

   typedef struct {
      req_type req;
      bit      typed;
      rsp_type want;
   } stim_row_type;

   task automatic report_error(input string what);
      $display("%0t mismatch: %s", $time, what);
      error_count++;
   endtask

   function automatic logic [63:0] splitmix(input logic [63:0] x);
      x = x ^ (x >> 33);
      x = x * MIX1;
      x = x ^ (x >> 33);
      x = x * MIX2;
      x = x ^ (x >> 33);
      return x;
   endfunction

   function automatic int unsigned lane_index(input logic [31:0] page, input int unsigned row);
      int unsigned w;
      logic [63:0] h;
      int unsigned l;
      w = (cfg_width == 0) ? 1 : (cfg_width > MAX_WIDTH) ? MAX_WIDTH : cfg_width;
      h = splitmix({32'd0, page} * GOLD + 64'(row) * ROWK);
      l = row * w + int'(h % 64'(w));
      return (l < STORE) ? l : 0;
   endfunction

   function automatic logic [7:0] min_count(input logic [31:0] page);
      logic [7:0] m;
      m = 8'hff;
      if (!cfg_enable) return 8'd0;
      for (int r = 0; r < ROWS; r++)
         if (shadow_cnt[lane_index(page, r)] < m) m = shadow_cnt[lane_index(page, r)];
      return m;
   endfunction

   // returns 1 and the response when the request produces one
   function automatic bit predict_sketch(input req_type rq, output rsp_type rs);
      int unsigned l;
      rs = '0;
      case (rq.action)
         ACT_RECORD: begin
            if (cfg_enable) begin
               shadow_records++;
               if (cfg_aging != 0 && shadow_records % cfg_aging == 0)
                  for (int i = 0; i < STORE; i++) shadow_cnt[i] = shadow_cnt[i] >> 1;
               for (int r = 0; r < ROWS; r++) begin
                  l = lane_index(rq.page, r);
                  if (shadow_cnt[l] != 8'hff) shadow_cnt[l]++;
               end
            end
            return 0;
         end
         ACT_ESTIMATE: begin
            rs.estimate = min_count(rq.page);
            return 1;
         end
         ACT_COMPARE: begin
            rs.estimate = min_count(rq.page);
            rs.victim_estimate = rq.has_victim ? min_count(rq.victim_page) : 8'd0;
            rs.loses = rq.has_victim && rs.estimate <= rs.victim_estimate;
            return 1;
         end
         default: return 0;
      endcase
   endfunction

   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid) begin
         if (pending_rsp.size() == 0) report_error("response with nothing pending");
         else begin
            e = pending_rsp.pop_front();
            if (rsp_data.estimate !== e.estimate)
               report_error($sformatf("estimate %0d want %0d", rsp_data.estimate, e.estimate));
            if (rsp_data.victim_estimate !== e.victim_estimate)
               report_error($sformatf("victim_estimate %0d want %0d",
                                      rsp_data.victim_estimate, e.victim_estimate));
            if (rsp_data.loses !== e.loses)
               report_error($sformatf("loses %0b want %0b", rsp_data.loses, e.loses));
         end
      end
   end

   task automatic idle_gap();
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
   endtask

   // start stays high after the accepting edge; the next request, an idle
   // cycle or a drain takes it down
   task automatic send_request(input req_type rq, input bit typed, input rsp_type want);
      rsp_type p;
      idle_gap();
      start <= 1'b1;
      req_data <= rq;
      do @(posedge clock); while (busy);
      if (predict_sketch(rq, p)) begin
         if (typed && p !== want) report_error("directed row disagrees with predictor");
         pending_rsp = {pending_rsp, p};
      end
   endtask

   // waits out results, then the worst-case record with an aging sweep
   task automatic drain();
      start <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (10000) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         REG_ENABLE: cfg_enable = val[0];
         REG_WIDTH:  cfg_width = val[10:0];
         REG_AGING:  cfg_aging = val;
         default: ;
      endcase
      @(posedge clock);
   endtask

   function automatic req_type rand_req(input bit [31:0] hot);
      req_type rq;
      int k;
      k = $urandom_range(99);
      rq.action = (k < 50) ? ACT_RECORD : (k < 65) ? ACT_ESTIMATE : (k < 97) ? ACT_COMPARE
                                                                         : ACT_NONE;
      rq.page = $urandom_range(3) != 0 ? hot + $urandom_range(7) : $urandom;
      rq.victim_page = $urandom_range(1) ? hot + $urandom_range(7) : $urandom;
      rq.has_victim = $urandom_range(3) != 0;
      return rq;
   endfunction

   initial begin
      stim_row_type rows [$];
      stim_row_type s;
      bit [31:0] hot;
      for (int i = 0; i < STORE; i++) shadow_cnt[i] = '0;
      shadow_records = '0;
      cfg_enable = 1'b0;
      cfg_width = 11'd1024;
      cfg_aging = 32'd4096;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (busy) @(posedge clock);

      // disabled after reset: everything reads zero, compare loses iff victim present
      s.typed = 1;
      s.req = '{ACT_ESTIMATE, 32'hffff_ffff, 32'd0, 1'b1};     s.want = '{0, 0, 0};
      rows = {rows, s};
      s.req = '{ACT_COMPARE, 32'd0, 32'hffff_ffff, 1'b1};      s.want = '{0, 0, 1};
      rows = {rows, s};
      s.req = '{ACT_COMPARE, 32'd5, 32'd6, 1'b0};              s.want = '{0, 0, 0};
      rows = {rows, s};
      s.req = '{ACT_RECORD, 32'd7, 32'd0, 1'b0};               s.want = '0;
      rows = {rows, s};
      s.req = '{ACT_NONE, 32'hffff_ffff, 32'hffff_ffff, 1'b1}; s.want = '0;
      rows = {rows, s};
      foreach (rows[i]) send_request(rows[i].req, rows[i].typed, rows[i].want);
      drain();

      // enabled, width 1: every page shares one lane per row; period 3 ages often
      write_reg(REG_ENABLE, 32'd1);
      write_reg(REG_WIDTH, 32'd1);
      write_reg(REG_AGING, 32'd3);
      rows.delete();
      s.typed = 0;
      s.want = '0;
      for (int i = 0; i < 8; i++) begin
         s.req = '{ACT_RECORD, (i[0] ? 32'hffff_ffff : 32'd0), 32'd0, 1'b0};
         rows = {rows, s};
      end
      s.req = '{ACT_ESTIMATE, 32'd0, 32'd0, 1'b0};                 rows = {rows, s};
      s.req = '{ACT_COMPARE, 32'd1, 32'hffff_ffff, 1'b1};          rows = {rows, s};
      s.req = '{ACT_COMPARE, 32'h8000_0000, 32'h7fff_ffff, 1'b0};  rows = {rows, s};
      foreach (rows[i]) send_request(rows[i].req, rows[i].typed, rows[i].want);
      drain();

      // width 0 acts as 1, width above max saturates; aging off then the extreme period
      write_reg(REG_WIDTH, 32'd0);
      write_reg(REG_AGING, 32'd0);
      for (int i = 0; i < 4; i++) send_request('{ACT_RECORD, $urandom, 0, 0}, 0, '0);
      send_request('{ACT_COMPARE, 32'd3, 32'd9, 1'b1}, 0, '0);
      drain();
      write_reg(REG_WIDTH, 32'h7ff);
      write_reg(REG_AGING, 32'hffff_ffff);
      send_request('{ACT_RECORD, 32'd42, 0, 0}, 0, '0);
      send_request('{ACT_COMPARE, 32'd42, 32'd43, 1'b1}, 0, '0);
      drain();

      // random phases over several settings
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin write_reg(REG_WIDTH, 32'd16);  write_reg(REG_AGING, 32'd40); end
            1: begin write_reg(REG_WIDTH, 32'd1024); write_reg(REG_AGING, 32'd4096); end
            2: begin write_reg(REG_WIDTH, 32'd3);   write_reg(REG_AGING, 32'd7); end
            3: write_reg(REG_ENABLE, 32'd0);
            4: begin write_reg(REG_ENABLE, 32'd1); write_reg(REG_WIDTH, $urandom_range(1, 1024)); end
            default: write_reg(REG_AGING, $urandom_range(1, 200));
         endcase
         idle_pct = (ph == 1) ? 0 : 22;
         hot = $urandom;
         for (int i = 0; i < 150; i++) begin
            if (i == 75 && ph == 2) begin
               start <= 1'b0;
               do @(posedge clock); while (pending_rsp.size() != 0);
            end
            send_request(rand_req(hot), 0, '0);
         end
         drain();
      end

      if (error_count == 0) $display("count_min_frequency_sketch_tb: clean");
      else $display("count_min_frequency_sketch_tb: errors");
      $finish;
   end

   initial begin
      #(12 * 40000000);
      $display("count_min_frequency_sketch_tb: errors");
      $finish;
   end
endmodule
